FILE: rtl/core/mccd_pkg.sv
// ============================================================================
// MIDI control-change decoder package
// Shared constants, codes and control/status types for the decoder block.
// ============================================================================
`default_nettype none

package mccd_pkg;

    // Slot counts of the four controller groups.
    localparam int SLIDER_COUNT        = 9;
    localparam int KNOB_COUNT          = 9;
    localparam int BUTTON_COUNT        = 9;
    localparam int SYSTEM_BUTTON_COUNT = 6;

    localparam int LEVEL_SLOTS = SLIDER_COUNT + KNOB_COUNT;
    localparam int FLAG_SLOTS  = BUTTON_COUNT + SYSTEM_BUTTON_COUNT;
    localparam int ALL_SLOTS   = LEVEL_SLOTS + FLAG_SLOTS;

    localparam int LEVEL_IDX_W = (LEVEL_SLOTS > 1) ? $clog2(LEVEL_SLOTS) : 1;
    localparam int FLAG_IDX_W  = (FLAG_SLOTS > 1) ? $clog2(FLAG_SLOTS) : 1;

    // MIDI constants.
    localparam logic [7:0] CC_STATUS   = 8'hB0;
    localparam logic [7:0] PRESS_VALUE = 8'd127;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_ENABLE       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_INTERVAL     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLIDER_BASE        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KNOB_BASE          = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUTTON_BASE        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYSTEM_BUTTON_BASE = 3'd5;

    // Register reset values.
    localparam logic        RST_BLOCK_ENABLE       = 1'b1;
    localparam logic [15:0] RST_PRESS_INTERVAL     = 16'd100;
    localparam logic [6:0]  RST_SLIDER_BASE        = 7'd3;
    localparam logic [6:0]  RST_KNOB_BASE          = 7'd14;
    localparam logic [6:0]  RST_BUTTON_BASE        = 7'd23;
    localparam logic [6:0]  RST_SYSTEM_BUTTON_BASE = 7'd44;

    // Read status codes.
    localparam logic [1:0] RS_OK       = 2'd0;
    localparam logic [1:0] RS_DISABLED = 2'd1;
    localparam logic [1:0] RS_RANGE    = 2'd2;

    // Decoded operation of one item.
    typedef enum logic [2:0] {
        OP_NONE        = 3'd0,
        OP_LEVEL       = 3'd1,
        OP_BUTTON      = 3'd2,
        OP_SYSTEM      = 3'd3,
        OP_RD_DISABLED = 3'd4,
        OP_RD_RANGE    = 3'd5,
        OP_RD_LEVEL    = 3'd6,
        OP_RD_FLAG     = 3'd7
    } op_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_item;
        logic decode;
        logic apply;
    } mccd_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic is_read;
    } mccd_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/mccd_ctrl.sv
// ============================================================================
// MIDI control-change decoder controller
// Sequences one item through load, decode, apply and, for a read, result hand-off.
// ============================================================================
`default_nettype none

module mccd_ctrl
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  item_valid,
    output logic                 item_stall,
    output logic                 result_valid,
    input  wire                  result_stall,
    output mccd_pkg::mccd_cmd_t  cmd,
    input  mccd_pkg::mccd_stat_t stat
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECODE = 4'b0010,
        ST_APPLY  = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                state_next = stat.is_read ? ST_RESULT : ST_IDLE;
            end
            ST_RESULT:
            begin
                if (!result_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_stall    = (state_reg != ST_IDLE);
    assign result_valid  = (state_reg == ST_RESULT);
    assign cmd.load_item = (state_reg == ST_IDLE) && item_valid;
    assign cmd.decode    = (state_reg == ST_DECODE);
    assign cmd.apply     = (state_reg == ST_APPLY);

endmodule

`default_nettype wire

FILE: rtl/core/mccd_datapath.sv
// ============================================================================
// MIDI control-change decoder datapath
// Configuration registers, slot decode, level and press state, read results.
// ============================================================================
`default_nettype none

module mccd_datapath
(
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  mccd_pkg::mccd_cmd_t                   cmd,
    output mccd_pkg::mccd_stat_t                  stat,
    input  wire                                   cfg_write_en,
    input  wire [mccd_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire [mccd_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  wire                                   command,
    input  wire [7:0]                             midi_status,
    input  wire [7:0]                             controller_number,
    input  wire [7:0]                             control_value,
    input  wire [31:0]                            event_time,
    input  wire [5:0]                             read_address,
    output logic [1:0]                            read_status,
    output logic [7:0]                            level_value,
    output logic                                  level_seen,
    output logic                                  press_flag
);

    localparam int LW = mccd_pkg::LEVEL_IDX_W;
    localparam int FW = mccd_pkg::FLAG_IDX_W;

    // Configuration registers.
    logic        enable_reg;
    logic [15:0] interval_reg;
    logic [6:0]  slider_base_reg;
    logic [6:0]  knob_base_reg;
    logic [6:0]  button_base_reg;
    logic [6:0]  system_base_reg;

    // Captured item.
    logic        command_reg;
    logic [7:0]  status_reg;
    logic [7:0]  name_reg;
    logic [7:0]  value_reg;
    logic [31:0] time_reg;
    logic [5:0]  addr_reg;

    // Decode results.
    mccd_pkg::op_t op_reg;
    mccd_pkg::op_t op_next;
    logic [LW-1:0] lslot_reg;
    logic [LW-1:0] lslot_next;
    logic [FW-1:0] fslot_reg;
    logic [FW-1:0] fslot_next;

    // Slot state.
    logic [7:0]  levels_reg [mccd_pkg::LEVEL_SLOTS];
    logic        seen_reg   [mccd_pkg::LEVEL_SLOTS];
    logic        flags_reg  [mccd_pkg::FLAG_SLOTS];
    logic [31:0] last_reg   [mccd_pkg::FLAG_SLOTS];

    // Result registers.
    logic [1:0] read_status_reg;
    logic [7:0] level_value_reg;
    logic       level_seen_reg;
    logic       press_flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= mccd_pkg::RST_BLOCK_ENABLE;
            interval_reg    <= mccd_pkg::RST_PRESS_INTERVAL;
            slider_base_reg <= mccd_pkg::RST_SLIDER_BASE;
            knob_base_reg   <= mccd_pkg::RST_KNOB_BASE;
            button_base_reg <= mccd_pkg::RST_BUTTON_BASE;
            system_base_reg <= mccd_pkg::RST_SYSTEM_BUTTON_BASE;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                mccd_pkg::CFG_BLOCK_ENABLE:       enable_reg      <= cfg_data[0];
                mccd_pkg::CFG_PRESS_INTERVAL:     interval_reg    <= cfg_data;
                mccd_pkg::CFG_SLIDER_BASE:        slider_base_reg <= cfg_data[6:0];
                mccd_pkg::CFG_KNOB_BASE:          knob_base_reg   <= cfg_data[6:0];
                mccd_pkg::CFG_BUTTON_BASE:        button_base_reg <= cfg_data[6:0];
                mccd_pkg::CFG_SYSTEM_BUTTON_BASE: system_base_reg <= cfg_data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            command_reg <= command;
            status_reg  <= midi_status;
            name_reg    <= controller_number;
            value_reg   <= control_value;
            time_reg    <= event_time;
            addr_reg    <= read_address;
        end
    end

    // Range checks: a negative difference sets bit 8.
    logic [8:0] slider_diff;
    logic [8:0] knob_diff;
    logic [8:0] button_diff;
    logic [8:0] system_diff;
    logic       slider_hit;
    logic       knob_hit;
    logic       button_hit;
    logic       system_hit;
    logic [5:0] flag_addr;

    assign slider_diff = {1'b0, name_reg} - {2'b0, slider_base_reg};
    assign knob_diff   = {1'b0, name_reg} - {2'b0, knob_base_reg};
    assign button_diff = {1'b0, name_reg} - {2'b0, button_base_reg};
    assign system_diff = {1'b0, name_reg} - {2'b0, system_base_reg};

    assign slider_hit = !slider_diff[8] && (slider_diff[7:0] < 8'(mccd_pkg::SLIDER_COUNT));
    assign knob_hit   = !knob_diff[8] && (knob_diff[7:0] < 8'(mccd_pkg::KNOB_COUNT));
    assign button_hit = !button_diff[8] && (button_diff[7:0] < 8'(mccd_pkg::BUTTON_COUNT));
    assign system_hit = !system_diff[8]
                        && (system_diff[7:0] < 8'(mccd_pkg::SYSTEM_BUTTON_COUNT));

    assign flag_addr = addr_reg - 6'(mccd_pkg::LEVEL_SLOTS);

    always_comb
    begin
        op_next    = mccd_pkg::OP_NONE;
        lslot_next = '0;
        fslot_next = '0;
        if (command_reg)
        begin
            if (!enable_reg)
            begin
                op_next = mccd_pkg::OP_RD_DISABLED;
            end
            else if ({1'b0, addr_reg} >= 7'(mccd_pkg::ALL_SLOTS))
            begin
                op_next = mccd_pkg::OP_RD_RANGE;
            end
            else if ({1'b0, addr_reg} < 7'(mccd_pkg::LEVEL_SLOTS))
            begin
                op_next    = mccd_pkg::OP_RD_LEVEL;
                lslot_next = addr_reg[LW-1:0];
            end
            else
            begin
                op_next    = mccd_pkg::OP_RD_FLAG;
                fslot_next = flag_addr[FW-1:0];
            end
        end
        else if (status_reg == mccd_pkg::CC_STATUS)
        begin
            if (slider_hit)
            begin
                op_next    = mccd_pkg::OP_LEVEL;
                lslot_next = slider_diff[LW-1:0];
            end
            else if (knob_hit)
            begin
                op_next    = mccd_pkg::OP_LEVEL;
                lslot_next = LW'(mccd_pkg::SLIDER_COUNT) + knob_diff[LW-1:0];
            end
            else if (button_hit)
            begin
                op_next    = mccd_pkg::OP_BUTTON;
                fslot_next = button_diff[FW-1:0];
            end
            else if (system_hit)
            begin
                op_next    = mccd_pkg::OP_SYSTEM;
                fslot_next = FW'(mccd_pkg::BUTTON_COUNT) + system_diff[FW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decode)
        begin
            op_reg    <= op_next;
            lslot_reg <= lslot_next;
            fslot_reg <= fslot_next;
        end
    end

    // Press lockout: elapsed time is taken modulo 2^32.
    logic [31:0] elapsed;
    logic        press_ok;
    logic        is_press;

    assign elapsed  = time_reg - last_reg[fslot_reg];
    assign press_ok = elapsed > {16'b0, interval_reg};
    assign is_press = (value_reg == mccd_pkg::PRESS_VALUE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mccd_pkg::LEVEL_SLOTS; i++)
            begin
                levels_reg[i] <= '0;
                seen_reg[i]   <= 1'b0;
            end
            for (int i = 0; i < mccd_pkg::FLAG_SLOTS; i++)
            begin
                flags_reg[i] <= 1'b0;
                last_reg[i]  <= '0;
            end
        end
        else if (cmd.apply)
        begin
            case (op_reg)
                mccd_pkg::OP_LEVEL:
                begin
                    levels_reg[lslot_reg] <= value_reg;
                    seen_reg[lslot_reg]   <= 1'b1;
                end
                mccd_pkg::OP_BUTTON,
                mccd_pkg::OP_SYSTEM:
                begin
                    if (is_press)
                    begin
                        if (press_ok)
                        begin
                            flags_reg[fslot_reg] <= 1'b1;
                            last_reg[fslot_reg]  <= time_reg;
                        end
                    end
                    else if (op_reg == mccd_pkg::OP_BUTTON)
                    begin
                        flags_reg[fslot_reg] <= 1'b0;
                    end
                end
                mccd_pkg::OP_RD_FLAG:
                begin
                    flags_reg[fslot_reg] <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            read_status_reg <= mccd_pkg::RS_OK;
            level_value_reg <= '0;
            level_seen_reg  <= 1'b0;
            press_flag_reg  <= 1'b0;
            case (op_reg)
                mccd_pkg::OP_RD_DISABLED:
                begin
                    read_status_reg <= mccd_pkg::RS_DISABLED;
                end
                mccd_pkg::OP_RD_RANGE:
                begin
                    read_status_reg <= mccd_pkg::RS_RANGE;
                end
                mccd_pkg::OP_RD_LEVEL:
                begin
                    level_value_reg <= levels_reg[lslot_reg];
                    level_seen_reg  <= seen_reg[lslot_reg];
                end
                mccd_pkg::OP_RD_FLAG:
                begin
                    press_flag_reg <= flags_reg[fslot_reg];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign stat.is_read = command_reg;
    assign read_status  = read_status_reg;
    assign level_value  = level_value_reg;
    assign level_seen   = level_seen_reg;
    assign press_flag   = press_flag_reg;

endmodule

`default_nettype wire

FILE: rtl/core/midi_control_change_decoder.sv
// ============================================================================
// MIDI control-change decoder
// Decodes channel-0 control changes into slider and knob levels and
// debounced button press flags, and answers read accesses to that state.
// ============================================================================
//
//  Channel   Direction  Handshake                   Contents
//  --------  ---------  --------------------------  --------------------------------
//  item      in         item_valid / item_stall     MIDI message or read access
//  result    out        result_valid / result_stall one result per read access
//  config    in         cfg_write_en, cfg_index     block_enable, press_interval,
//                                                   and the four range bases
//
// One item is in flight at a time. A MIDI message passes through capture, decode
// and apply; a read also passes through the result state, where the controller
// waits for as long as its result transfer is stalled.
// The 32-bit lockout subtract and compare behind the slot select sets the apply depth.
// Reset restores the register defaults and clears all levels, seen bits, press
// flags and last press times; item_stall is low right after reset.
//
`default_nettype none

module midi_control_change_decoder
(
    input  wire                             clk,
    input  wire                             rst_n,

    input  wire                             cfg_write_en,
    input  wire [mccd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire [mccd_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  wire                             item_valid,
    output logic                            item_stall,
    input  wire                             command,
    input  wire [7:0]                       midi_status,
    input  wire [7:0]                       controller_number,
    input  wire [7:0]                       control_value,
    input  wire [31:0]                      event_time,
    input  wire [5:0]                       read_address,

    output logic                            result_valid,
    input  wire                             result_stall,
    output logic [1:0]                      read_status,
    output logic [7:0]                      level_value,
    output logic                            level_seen,
    output logic                            press_flag
);

    // Commands flow from the controller into the datapath; the datapath only
    // reports back whether the captured item is a read, which decides whether
    // the controller must present a result transfer.
    mccd_pkg::mccd_cmd_t  cmd;
    mccd_pkg::mccd_stat_t stat;

    mccd_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .stat         (stat)
    );

    // The datapath holds the configuration, the captured item, the decoded
    // slot, all per-slot state and the result registers. Result registers
    // are loaded only in the apply step, so they hold steady while stalled.
    mccd_datapath u_datapath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_write_en      (cfg_write_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .command           (command),
        .midi_status       (midi_status),
        .controller_number (controller_number),
        .control_value     (control_value),
        .event_time        (event_time),
        .read_address      (read_address),
        .read_status       (read_status),
        .level_value       (level_value),
        .level_seen        (level_seen),
        .press_flag        (press_flag)
    );

endmodule

`default_nettype wire
